/* hdl/sidec_pkg.sv */
package sidec_pkg;

    localparam int WORD_W     = 32;
    localparam int NUM_DIGITS = 10;
    localparam int DIGIT_W    = 4;
    localparam int CHAR_W     = 8;
    localparam int BIT_CNT_W  = $clog2(WORD_W);
    localparam int DIG_CNT_W  = $clog2(NUM_DIGITS + 1);

    localparam logic [CHAR_W-1:0] ASCII_ZERO  = 8'd48;
    localparam logic [CHAR_W-1:0] ASCII_MINUS = 8'd45;

    // Cell operation for the current cycle; at most one is set.
    typedef struct packed {
        logic clear;   // load zero
        logic dabble;  // add-3 correct, then shift one binary bit in
        logic shift;   // take the neighbor's digit (move digits toward the top)
    } cell_ctrl_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CONVERT,
        ST_SIGN,
        ST_STRIP,
        ST_EMIT
    } state_t;

endpackage

/* hdl/sidec_cell.sv */
// One BCD digit of the double-dabble chain.
module sidec_cell
(
    input  logic                                clk,
    input  sidec_pkg::cell_ctrl_t               ctrl,
    input  logic                                bit_in,
    input  logic [sidec_pkg::DIGIT_W-1:0]       digit_in,
    output logic                                bit_out,
    output logic [sidec_pkg::DIGIT_W-1:0]       digit
);

    logic [sidec_pkg::DIGIT_W-1:0] digit_reg;
    logic [sidec_pkg::DIGIT_W-1:0] digit_next;
    logic [sidec_pkg::DIGIT_W-1:0] adj;

    // Correct digits of five or more so the doubling carries into the next cell.
    assign adj     = (digit_reg >= 4'd5) ? (digit_reg + 4'd3) : digit_reg;
    assign bit_out = adj[sidec_pkg::DIGIT_W-1];
    assign digit   = digit_reg;

    always_comb
    begin
        digit_next = digit_reg;
        if (ctrl.clear)
        begin
            digit_next = '0;
        end
        else if (ctrl.dabble)
        begin
            digit_next = {adj[sidec_pkg::DIGIT_W-2:0], bit_in};
        end
        else if (ctrl.shift)
        begin
            digit_next = digit_in;
        end
    end

    always_ff @(posedge clk)
    begin
        digit_reg <= digit_next;
    end

endmodule

/* hdl/signed_int_to_decimal_ascii_unit.sv */
// Signed 32-bit integer to decimal ASCII text.
//
// Request channel: drive value and pulse start while busy is low; the request
// is taken at that clock edge and busy rises on the next cycle.
// Result channel: each character appears on char_code for exactly one cycle,
// marked by result_valid; last_char flags the final character of the number.
// Characters come most significant first: an optional '-', then the digits
// with no leading zeros (zero gives a single '0').
//
// Timing: the magnitude is shifted bit-serially into a chain of ten BCD digit
// cells, one bit per cycle. A negative value then emits the '-'. The digit
// chain then moves up one digit per cycle: leading zeros are dropped silently,
// and each remaining digit is emitted. Busy stays high from acceptance through
// the 32-step conversion, the '-' and the digit shifts; start is only taken
// while busy is low, so a new request waits until the current number is done.
//
// Reset (rst_n, asynchronous, active low) returns to idle and drops any
// request in flight; no result is produced after reset until a new request.
// The receiver cannot stall: every result is presented once and never held.
module signed_int_to_decimal_ascii_unit
(
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                start,
    output logic                                busy,
    input  logic signed [sidec_pkg::WORD_W-1:0] value,
    output logic                                result_valid,
    output logic [sidec_pkg::CHAR_W-1:0]        char_code,
    output logic                                last_char
);

    localparam int NumDigits = sidec_pkg::NUM_DIGITS;

    sidec_pkg::state_t                   state_reg, state_next;
    logic [sidec_pkg::WORD_W-1:0]        mag_reg, mag_next;
    logic                                neg_reg, neg_next;
    logic [sidec_pkg::BIT_CNT_W-1:0]     bit_cnt_reg, bit_cnt_next;
    logic [sidec_pkg::DIG_CNT_W-1:0]     dig_cnt_reg, dig_cnt_next;

    logic                                result_valid_reg, result_valid_next;
    logic [sidec_pkg::CHAR_W-1:0]        char_code_reg, char_code_next;
    logic                                last_char_reg, last_char_next;

    sidec_pkg::cell_ctrl_t               cell_ctrl;
    logic [NumDigits-1:0]                carry;
    logic [sidec_pkg::DIGIT_W-1:0]       digits [NumDigits];
    logic [sidec_pkg::DIGIT_W-1:0]       top_digit;
    logic                                emit;

    // Cell 0 is the least significant digit; the top cell feeds the output.
    genvar gi;
    generate
        for (gi = 0; gi < NumDigits; gi++)
        begin : g_cell
            logic                          cin;
            logic [sidec_pkg::DIGIT_W-1:0] din;
            if (gi == 0)
            begin : g_first
                assign cin = mag_reg[sidec_pkg::WORD_W-1];
                assign din = '0;
            end
            else
            begin : g_rest
                assign cin = carry[gi-1];
                assign din = digits[gi-1];
            end
            sidec_cell u_cell
            (
                .clk      (clk),
                .ctrl     (cell_ctrl),
                .bit_in   (cin),
                .digit_in (din),
                .bit_out  (carry[gi]),
                .digit    (digits[gi])
            );
        end
    endgenerate

    assign top_digit = digits[NumDigits-1];

    // Emit the top digit once it is nonzero or it is the last one left.
    assign emit = (top_digit != '0) ||
                  (dig_cnt_reg == sidec_pkg::DIG_CNT_W'(1));

    always_comb
    begin
        state_next        = state_reg;
        mag_next          = mag_reg;
        neg_next          = neg_reg;
        bit_cnt_next      = bit_cnt_reg;
        dig_cnt_next      = dig_cnt_reg;
        result_valid_next = 1'b0;
        char_code_next    = char_code_reg;
        last_char_next    = last_char_reg;
        cell_ctrl         = '0;

        unique case (state_reg)
            sidec_pkg::ST_IDLE:
            begin
                if (start)
                begin
                    // Take the request: form the unsigned magnitude, clear the chain.
                    neg_next       = value[sidec_pkg::WORD_W-1];
                    mag_next       = value[sidec_pkg::WORD_W-1]
                                   ? (~unsigned'(value) + sidec_pkg::WORD_W'(1))
                                   : unsigned'(value);
                    bit_cnt_next   = '0;
                    dig_cnt_next   = sidec_pkg::DIG_CNT_W'(NumDigits);
                    cell_ctrl.clear = 1'b1;
                    state_next     = sidec_pkg::ST_CONVERT;
                end
            end

            sidec_pkg::ST_CONVERT:
            begin
                // Advance one magnitude bit into the digit chain, MSB first.
                cell_ctrl.dabble = 1'b1;
                mag_next         = {mag_reg[sidec_pkg::WORD_W-2:0], 1'b0};
                bit_cnt_next     = bit_cnt_reg + sidec_pkg::BIT_CNT_W'(1);
                if (bit_cnt_reg == sidec_pkg::BIT_CNT_W'(sidec_pkg::WORD_W - 1))
                begin
                    state_next = neg_reg ? sidec_pkg::ST_SIGN : sidec_pkg::ST_STRIP;
                end
            end

            sidec_pkg::ST_SIGN:
            begin
                result_valid_next = 1'b1;
                char_code_next    = sidec_pkg::ASCII_MINUS;
                last_char_next    = 1'b0;
                state_next        = sidec_pkg::ST_STRIP;
            end

            sidec_pkg::ST_STRIP,
            sidec_pkg::ST_EMIT:
            begin
                // While stripping, drop leading zeros without a result.
                cell_ctrl.shift = 1'b1;
                dig_cnt_next    = dig_cnt_reg - sidec_pkg::DIG_CNT_W'(1);
                if (emit || (state_reg == sidec_pkg::ST_EMIT))
                begin
                    result_valid_next = 1'b1;
                    char_code_next    = sidec_pkg::ASCII_ZERO
                                      + sidec_pkg::CHAR_W'(top_digit);
                    last_char_next    = (dig_cnt_reg == sidec_pkg::DIG_CNT_W'(1));
                    state_next        = sidec_pkg::ST_EMIT;
                end
                if (dig_cnt_reg == sidec_pkg::DIG_CNT_W'(1))
                begin
                    state_next = sidec_pkg::ST_IDLE;
                end
            end

            default:
            begin
                state_next = sidec_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= sidec_pkg::ST_IDLE;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg        <= state_next;
            result_valid_reg <= result_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        mag_reg       <= mag_next;
        neg_reg       <= neg_next;
        bit_cnt_reg   <= bit_cnt_next;
        dig_cnt_reg   <= dig_cnt_next;
        char_code_reg <= char_code_next;
        last_char_reg <= last_char_next;
    end

    assign busy         = (state_reg != sidec_pkg::ST_IDLE);
    assign result_valid = result_valid_reg;
    assign char_code    = char_code_reg;
    assign last_char    = last_char_reg;

endmodule
